>>> sv/som_pkg.sv
// Shared types, constants and helpers for the SOM winner search and update block.
package som_pkg;

	localparam int MAX_ROWS    = 8;
	localparam int MAX_COLS    = 8;
	localparam int DIMS        = 4;
	localparam int WEIGHT_BITS = 16;
	localparam int NEURONS     = MAX_ROWS * MAX_COLS;
	localparam int NB          = $clog2(NEURONS);
	localparam int RB          = $clog2(MAX_ROWS);
	localparam int CB          = $clog2(MAX_COLS);
	localparam int DIFF_BITS   = WEIGHT_BITS + 1;
	localparam int SQ_BITS     = 2 * DIFF_BITS;
	localparam int ACC_BITS    = SQ_BITS + $clog2(DIMS) + 1;
	localparam int PROD_BITS   = DIFF_BITS + 17;

	typedef enum logic [1:0] {
		OP_TRAIN    = 2'd0,
		OP_CLASSIFY = 2'd1,
		OP_LOAD     = 2'd2,
		OP_READ     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_RADIUS = 2'd0,
		MODE_FOUR   = 2'd1,
		MODE_EIGHT  = 2'd2,
		MODE_HEX    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_ROWS  = 3'd0,
		REG_COLS  = 3'd1,
		REG_MODE  = 3'd2,
		REG_REACH = 3'd3,
		REG_RATE0 = 3'd4,
		REG_RATE1 = 3'd5,
		REG_RATE2 = 3'd6
	} reg_t;

	typedef logic signed [WEIGHT_BITS-1:0] wvec_t [DIMS];

	// Controller to datapath
	typedef struct packed {
		logic          write_pat;  // capture pattern
		logic          load;       // write pattern into store at addr
		logic          rd;         // issue store read at addr
		logic          scan_first; // data back is neuron 0 of a scan
		logic          scan_data;  // data back belongs to scan
		logic          upd_data;   // data back belongs to an update
		logic          upd_wr;     // write updated vector at addr
		logic [NB-1:0] addr;
		logic [15:0]   gain;
		logic          out_load;   // register result word
		logic [1:0]    out_op;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [NB-1:0] best;
	} sts_t;

	function automatic logic [3:0] clamp_dim(input logic [3:0] v, input int mx);
		logic [3:0] r;
		if (v == 4'd0) r = 4'd1;
		else if (int'(v) > mx) r = 4'(mx);
		else r = v;
		return r;
	endfunction

endpackage

>>> sv/som_winner_search_and_update_top.sv
// Top level: SOM winner search and neighbourhood update with APB register file.
//
//  channel | direction | handshake        | payload
//  in      | into      | in_valid/in_stall | op, neuron, value_0..value_3
//  out     | out of    | out_valid/out_stall | winner, adapted_count, weight_0..3
//  cfg     | into      | APB psel/penable | paddr, pwdata, prdata
//
// Load and read words go from idle to the done state. Classify scans the rows*cols
// grid: the scan reads one weight vector a cycle from the single store port. Train
// adds 10 slots of read, wait and write-back; an empty slot stops at the read
// state and only a moved neuron goes on to wait and write-back.
// Reset clears control state and the registers; the weight store is not cleared.
// A stalled result word holds, and no new word is taken until it has gone.
module som_winner_search_and_update_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [5:0]  neuron,
	input  logic signed [15:0] value_0,
	input  logic signed [15:0] value_1,
	input  logic signed [15:0] value_2,
	input  logic signed [15:0] value_3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  winner,
	output logic [3:0]  adapted_count,
	output logic signed [15:0] weight_0,
	output logic signed [15:0] weight_1,
	output logic signed [15:0] weight_2,
	output logic signed [15:0] weight_3
);
	import som_pkg::*;

	logic [3:0]  rows_q, cols_q;
	logic [1:0]  mode_q, reach_q;
	logic [15:0] rate0_q, rate1_q, rate2_q;
	logic [2:0]  ridx;
	cmd_t        cmd;
	sts_t        sts;
	logic [3:0]  cnt;
	logic [5:0]  win_q;
	logic [3:0]  cnt_q;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];

	// Register file: write on the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 4'd8;
			cols_q <= 4'd8;
			mode_q <= MODE_RADIUS;
			reach_q <= 2'd2;
			rate0_q <= 16'd6554;
			rate1_q <= 16'd5000;
			rate2_q <= 16'd4000;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_ROWS:  rows_q <= pwdata[3:0];
				REG_COLS:  cols_q <= pwdata[3:0];
				REG_MODE:  mode_q <= pwdata[1:0];
				REG_REACH: reach_q <= pwdata[1:0];
				REG_RATE0: rate0_q <= pwdata[15:0];
				REG_RATE1: rate1_q <= pwdata[15:0];
				REG_RATE2: rate2_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_ROWS:  prdata = {28'd0, rows_q};
			REG_COLS:  prdata = {28'd0, cols_q};
			REG_MODE:  prdata = {30'd0, mode_q};
			REG_REACH: prdata = {30'd0, reach_q};
			REG_RATE0: prdata = {16'd0, rate0_q};
			REG_RATE1: prdata = {16'd0, rate1_q};
			REG_RATE2: prdata = {16'd0, rate2_q};
			default:   prdata = '0;
		endcase
	end

	som_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall,
		.in_op(op), .in_neuron(neuron),
		.out_valid, .out_stall,
		.rows_q, .cols_q, .mode_q, .reach_q, .rate0_q, .rate1_q, .rate2_q,
		.cmd, .sts, .count(cnt)
	);

	som_dp u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_v0(value_0), .in_v1(value_1), .in_v2(value_2), .in_v3(value_3),
		.w0(weight_0), .w1(weight_1), .w2(weight_2), .w3(weight_3)
	);

	// Result word: winner for search items, count for train items only.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			win_q <= (cmd.out_op == OP_TRAIN || cmd.out_op == OP_CLASSIFY) ? sts.best : '0;
			cnt_q <= (cmd.out_op == OP_TRAIN) ? cnt : '0;
		end
	end

	assign winner = win_q;
	assign adapted_count = cnt_q;

endmodule

>>> sv/som_ctrl.sv
// Controller: sequences load, read, winner scan and neighbourhood update.
module som_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 in_op,
	input  logic [som_pkg::NB-1:0]     in_neuron,
	output logic                       out_valid,
	input  logic                       out_stall,
	input  logic [3:0]                 rows_q,
	input  logic [3:0]                 cols_q,
	input  logic [1:0]                 mode_q,
	input  logic [1:0]                 reach_q,
	input  logic [15:0]                rate0_q,
	input  logic [15:0]                rate1_q,
	input  logic [15:0]                rate2_q,
	output som_pkg::cmd_t              cmd,
	input  som_pkg::sts_t              sts,
	output logic [3:0]                 count
);
	import som_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCAN  = 7'b0000010,
		ST_DRAIN = 7'b0000100,
		ST_URD   = 7'b0001000,
		ST_UWAIT = 7'b0010000,
		ST_UWR   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t          state_q;
	logic [1:0]      op_q;
	logic [NB:0]     scan_q;
	logic [2:0]      lag_q;
	logic [3:0]      slot_q;
	logic [3:0]      count_q;
	logic            out_valid_q;
	logic [NB-1:0]   tgt_q;
	logic [15:0]     gain_q;
	logic [3:0]      rows, cols;
	logic [NB:0]     size;
	logic [RB:0]     wrow;
	logic [CB:0]     wcol;
	logic            take;
	logic            slot_ok;
	logic [NB-1:0]   slot_n;
	logic [15:0]     slot_gain;
	logic            slot_cnt;
	logic signed [2:0] dr, dc;
	logic [1:0]      lim;
	logic [1:0]      span;
	logic            conn;
	logic signed [5:0] tr, tc;

	assign rows = clamp_dim(rows_q, MAX_ROWS);
	assign cols = clamp_dim(cols_q, MAX_COLS);
	assign size = (NB+1)'(rows) * (NB+1)'(cols);
	assign lim  = (reach_q > 2'd2) ? 2'd2 : reach_q;

	// Winner row and column by repeated subtraction would be long; cols is small,
	// so divide with a compare chain over the row count.
	always_comb begin
		wrow = '0;
		wcol = '0;
		for (int r = 0; r < MAX_ROWS; r++) begin
			if (int'(sts.best) >= r * int'(cols)) begin
				wrow = (RB+1)'(r);
				wcol = (CB+1)'(int'(sts.best) - r * int'(cols));
			end
		end
	end

	// Neighbour slot 0 is the winner core move (grid modes), 1..9 the 3x3 window.
	always_comb begin
		dr = 3'sd0;
		dc = 3'sd0;
		slot_ok = 1'b0;
		slot_cnt = 1'b0;
		slot_gain = rate0_q;
		span = 2'd0;
		conn = 1'b0;
		tr = '0;
		tc = '0;
		if (slot_q == 4'd0) begin
			slot_ok = (mode_q != MODE_RADIUS);
		end else begin
			if (slot_q inside {4'd1, 4'd2, 4'd3}) dr = -3'sd1;
			else if (slot_q inside {4'd4, 4'd5, 4'd6}) dr = 3'sd0;
			else dr = 3'sd1;
			if (slot_q inside {4'd1, 4'd4, 4'd7}) dc = -3'sd1;
			else if (slot_q inside {4'd2, 4'd5, 4'd8}) dc = 3'sd0;
			else dc = 3'sd1;
			tr = 6'(signed'({1'b0, wrow})) + 6'(dr);
			tc = 6'(signed'({1'b0, wcol})) + 6'(dc);
			span = 2'((dr != 0) ? 1 : 0) + 2'((dc != 0) ? 1 : 0);
			case (mode_q)
				MODE_RADIUS: conn = 1'b1;
				MODE_FOUR:   conn = (span == 2'd1);
				MODE_EIGHT:  conn = (span != 2'd0);
				default: begin
					if (dr == 0) conn = (dc != 0);
					else if (wrow[0]) conn = (dc == -3'sd1) || (dc == 3'sd0);
					else conn = (dc == 3'sd0) || (dc == 3'sd1);
				end
			endcase
			slot_ok = conn && (span <= lim) && (tr >= 0) && (tc >= 0)
				&& (tr < 6'(rows)) && (tc < 6'(cols));
			slot_cnt = 1'b1;
			case (span)
				2'd0: slot_gain = rate0_q;
				2'd1: slot_gain = rate1_q;
				default: slot_gain = rate2_q;
			endcase
		end
		slot_n = NB'(int'(tr) * int'(cols) + int'(tc));
		if (slot_q == 4'd0) slot_n = sts.best;
	end

	assign take = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;
	assign count = count_q;

	always_comb begin
		cmd = '0;
		cmd.addr = in_neuron;
		cmd.out_op = op_q;
		cmd.gain = gain_q;
		cmd.write_pat = take;
		cmd.load = take && (in_op == OP_LOAD);
		cmd.rd = take && (in_op == OP_READ);
		case (state_q)
			ST_SCAN: begin
				cmd.addr = scan_q[NB-1:0];
				cmd.rd = 1'b1;
			end
			ST_URD: begin
				cmd.addr = slot_n;
				cmd.rd = slot_ok;
			end
			ST_UWR: begin
				cmd.addr = tgt_q;
				cmd.upd_wr = 1'b1;
			end
			default: ;
		endcase
		cmd.scan_data = (state_q == ST_SCAN || state_q == ST_DRAIN) && lag_q[0];
		cmd.scan_first = cmd.scan_data && lag_q[1];
		cmd.upd_data = (state_q == ST_UWAIT);
		cmd.out_load = (state_q == ST_DONE) && !(out_valid_q && out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			op_q <= OP_TRAIN;
			scan_q <= '0;
			lag_q <= '0;
			slot_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						op_q <= in_op;
						count_q <= '0;
						if (in_op == OP_TRAIN || in_op == OP_CLASSIFY) begin
							state_q <= ST_SCAN;
							scan_q <= '0;
							lag_q <= '0;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					// lag_q[0]: read data valid this cycle, [1]: first neuron
					lag_q <= {1'b0, (scan_q == '0), 1'b1};
					scan_q <= scan_q + 1'b1;
					if (scan_q + 1'b1 >= size) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					lag_q <= '0;
					if (!lag_q[0]) begin
						slot_q <= '0;
						state_q <= (op_q == OP_TRAIN) ? ST_URD : ST_DONE;
					end
				end
				ST_URD: begin
					if (slot_ok) begin
						tgt_q <= slot_n;
						gain_q <= slot_gain;
						if (slot_cnt) count_q <= count_q + 1'b1;
						state_q <= ST_UWAIT;
					end else if (slot_q == 4'd9) begin
						state_q <= ST_DONE;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				ST_UWAIT: state_q <= ST_UWR;
				ST_UWR: begin
					if (slot_q == 4'd9) state_q <= ST_DONE;
					else begin
						slot_q <= slot_q + 1'b1;
						state_q <= ST_URD;
					end
				end
				ST_DONE: begin
					if (!(out_valid_q && out_stall)) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	property p_no_take_busy;
		@(posedge clk) disable iff (!arst_n) (state_q != ST_IDLE) |-> in_stall;
	endproperty
	a_no_take_busy: assert property (p_no_take_busy) else $error("input taken while busy");

	property p_count_max;
		@(posedge clk) disable iff (!arst_n) count_q <= 4'd9;
	endproperty
	a_count_max: assert property (p_count_max) else $error("adapted count overflow");

	property p_wr_after_wait;
		@(posedge clk) disable iff (!arst_n) (state_q == ST_UWR) |-> $past(state_q == ST_UWAIT);
	endproperty
	a_wr_after_wait: assert property (p_wr_after_wait) else $error("update write out of order");

	property p_out_from_done;
		@(posedge clk) disable iff (!arst_n) $rose(out_valid_q) |-> $past(state_q == ST_DONE);
	endproperty
	a_out_from_done: assert property (p_out_from_done) else $error("result word without finish");

endmodule

>>> sv/som_dp.sv
// Datapath: weight store, pattern, distance accumulate, best compare, update arithmetic.
module som_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  som_pkg::cmd_t                       cmd,
	output som_pkg::sts_t                       sts,
	input  logic signed [15:0]                  in_v0,
	input  logic signed [15:0]                  in_v1,
	input  logic signed [15:0]                  in_v2,
	input  logic signed [15:0]                  in_v3,
	output logic signed [15:0]                  w0,
	output logic signed [15:0]                  w1,
	output logic signed [15:0]                  w2,
	output logic signed [15:0]                  w3
);
	import som_pkg::*;

	logic [DIMS*WEIGHT_BITS-1:0] mem [NEURONS];
	logic [DIMS*WEIGHT_BITS-1:0] rdata_q;
	logic [DIMS*WEIGHT_BITS-1:0] upd_q;
	logic signed [WEIGHT_BITS-1:0] pat_q [DIMS];
	logic [NB-1:0] rd_addr_q;
	logic [NB-1:0] best_idx_q;
	logic [ACC_BITS-1:0] best_q;
	logic [ACC_BITS-1:0] acc;
	logic [DIMS*WEIGHT_BITS-1:0] upd;
	logic signed [15:0] rd_w [DIMS];
	logic signed [15:0] res_q [DIMS];

	always_comb begin
		acc = '0;
		upd = '0;
		for (int d = 0; d < DIMS; d++) begin
			logic signed [WEIGHT_BITS-1:0] w;
			logic signed [DIFF_BITS-1:0] df;
			logic signed [PROD_BITS-1:0] t;
			logic signed [PROD_BITS-1:0] nw;
			logic [DIFF_BITS-1:0] a;
			w = rdata_q[d*WEIGHT_BITS +: WEIGHT_BITS];
			df = DIFF_BITS'(w) - DIFF_BITS'(pat_q[d]);
			a = df[DIFF_BITS-1] ? DIFF_BITS'(-df) : DIFF_BITS'(df);
			acc = acc + ACC_BITS'(SQ_BITS'(a) * SQ_BITS'(a));
			t = PROD_BITS'(signed'({1'b0, cmd.gain})) * PROD_BITS'(-df) + PROD_BITS'(32768);
			nw = PROD_BITS'(w) + (t >>> 16);
			if (nw > PROD_BITS'(32767)) nw = PROD_BITS'(32767);
			else if (nw < -PROD_BITS'(32768)) nw = -PROD_BITS'(32768);
			upd[d*WEIGHT_BITS +: WEIGHT_BITS] = WEIGHT_BITS'(nw);
			rd_w[d] = w;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write_pat) begin
			pat_q[0] <= in_v0;
			pat_q[1] <= in_v1;
			pat_q[2] <= in_v2;
			pat_q[3] <= in_v3;
		end
		if (cmd.load) mem[cmd.addr] <= {in_v3, in_v2, in_v1, in_v0};
		else if (cmd.upd_wr) mem[cmd.addr] <= upd_q;
		if (cmd.rd) rdata_q <= mem[cmd.addr];
		if (cmd.rd) rd_addr_q <= cmd.addr;
		if (cmd.upd_data) upd_q <= upd;
		if (cmd.out_load) begin
			for (int d = 0; d < DIMS; d++)
				res_q[d] <= (cmd.out_op == OP_READ) ? rd_w[d] : 16'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
			best_idx_q <= '0;
		end else if (cmd.scan_data) begin
			if (cmd.scan_first || acc < best_q) begin
				best_q <= acc;
				best_idx_q <= rd_addr_q;
			end
		end
	end

	assign sts.best = best_idx_q;
	assign w0 = res_q[0];
	assign w1 = res_q[1];
	assign w2 = res_q[2];
	assign w3 = res_q[3];

	property p_first_sets;
		@(posedge clk) disable iff (!arst_n) cmd.scan_first |-> cmd.scan_data;
	endproperty
	a_first_sets: assert property (p_first_sets) else $error("scan start without data");

	property p_no_clash;
		@(posedge clk) disable iff (!arst_n) !(cmd.load && cmd.upd_wr);
	endproperty
	a_no_clash: assert property (p_no_clash) else $error("two store writes at once");

	property p_best_kept;
		@(posedge clk) disable iff (!arst_n)
			!$past(cmd.scan_data) && !cmd.scan_data |=> $stable(best_idx_q);
	endproperty
	a_best_kept: assert property (p_best_kept) else $error("winner changed outside scan");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the SOM winner search and neighbourhood update block.
`timescale 1ns / 1ps

import som_pkg::*;

// Predicted result words, queued in acceptance order and matched against the block.
class som_scoreboard;
	logic signed [15:0] wts [NEURONS][DIMS];
	logic [3:0]  rows_cfg, cols_cfg;
	logic [1:0]  mode_cfg, reach_cfg;
	logic [15:0] gain_cfg [3];
	logic [5:0]  exp_winner [$];
	logic [3:0]  exp_count [$];
	logic [15:0] exp_w0 [$], exp_w1 [$], exp_w2 [$], exp_w3 [$];
	int          failures;

	function new();
		rows_cfg = 8; cols_cfg = 8; mode_cfg = MODE_RADIUS; reach_cfg = 2;
		gain_cfg[0] = 6554; gain_cfg[1] = 5000; gain_cfg[2] = 4000;
		failures = 0;
	endfunction

	function int pending();
		return exp_winner.size();
	endfunction

	function void set_reg(reg_t idx, logic [31:0] val);
		case (idx)
			REG_ROWS:  rows_cfg = val[3:0];
			REG_COLS:  cols_cfg = val[3:0];
			REG_MODE:  mode_cfg = val[1:0];
			REG_REACH: reach_cfg = val[1:0];
			REG_RATE0: gain_cfg[0] = val[15:0];
			REG_RATE1: gain_cfg[1] = val[15:0];
			default:   gain_cfg[2] = val[15:0];
		endcase
	endfunction

	function void pull_toward(int n, logic [15:0] gain, longint pat [4]);
		longint diff, t, sh, nv;
		for (int d = 0; d < DIMS; d++) begin
			diff = pat[d] - longint'(wts[n][d]);
			t = longint'({1'b0, gain}) * diff + 32768;
			sh = t >>> 16;
			nv = longint'(wts[n][d]) + sh;
			if (nv > 32767) nv = 32767;
			if (nv < -32768) nv = -32768;
			wts[n][d] = nv[15:0];
		end
	endfunction

	function bit linked(int dr, int dc, int wrow);
		int adr, adc;
		adr = dr < 0 ? -dr : dr;
		adc = dc < 0 ? -dc : dc;
		if (adr == 0 && adc == 0) return 0;
		if (mode_cfg == MODE_FOUR) return adr + adc == 1;
		if (mode_cfg == MODE_EIGHT) return adr <= 1 && adc <= 1;
		if (adr == 0) return adc == 1;
		if (adr != 1) return 0;
		return wrow[0] ? (dc == -1 || dc == 0) : (dc == 0 || dc == 1);
	endfunction

	// Note one accepted word and queue what the block should answer.
	function void note_word(op_t opc, logic [5:0] idx, logic signed [15:0] v [4]);
		longint pat [4];
		longint acc, best, df;
		int rows, cols, size, lim, win, cnt, dr, dc, span;
		logic [15:0] r [4];
		for (int d = 0; d < 4; d++) begin
			pat[d] = v[d];
			r[d] = 0;
		end
		rows = rows_cfg == 0 ? 1 : (rows_cfg > MAX_ROWS ? MAX_ROWS : rows_cfg);
		cols = cols_cfg == 0 ? 1 : (cols_cfg > MAX_COLS ? MAX_COLS : cols_cfg);
		size = rows * cols;
		lim = reach_cfg > 2 ? 2 : reach_cfg;
		win = 0; cnt = 0; best = 0;
		if (opc == OP_LOAD) begin
			for (int d = 0; d < DIMS; d++) wts[idx][d] = v[d];
		end else if (opc == OP_READ) begin
			for (int d = 0; d < DIMS; d++) r[d] = wts[idx][d];
		end else begin
			for (int n = 0; n < size; n++) begin
				acc = 0;
				for (int d = 0; d < DIMS; d++) begin
					df = longint'(wts[n][d]) - pat[d];
					acc += df * df;
				end
				if (n == 0 || acc < best) begin
					best = acc;
					win = n;
				end
			end
			if (opc == OP_TRAIN) begin
				if (mode_cfg != MODE_RADIUS) pull_toward(win, gain_cfg[0], pat);
				for (int n = 0; n < size; n++) begin
					dr = n / cols - win / cols;
					dc = n % cols - win % cols;
					span = dr * dr + dc * dc;
					if (span > lim) continue;
					if (mode_cfg != MODE_RADIUS && !linked(dr, dc, win / cols)) continue;
					pull_toward(n, gain_cfg[span], pat);
					cnt++;
				end
			end
		end
		exp_winner = {exp_winner, win[5:0]};
		exp_count = {exp_count, cnt[3:0]};
		exp_w0 = {exp_w0, r[0]}; exp_w1 = {exp_w1, r[1]};
		exp_w2 = {exp_w2, r[2]}; exp_w3 = {exp_w3, r[3]};
	endfunction

	function void cmp(string name, logic [15:0] e, logic [15:0] a);
		if (e !== a) begin
			$error("%s: expected %h, got %h", name, e, a);
			failures++;
		end
	endfunction

	// Check one result word against the oldest prediction.
	function void check_word(logic [5:0] w, logic [3:0] c, logic [15:0] a [4]);
		if (exp_winner.size() == 0) begin
			$error("result word with nothing expected");
			failures++;
			return;
		end
		cmp("winner", exp_winner.pop_front(), w);
		cmp("adapted_count", exp_count.pop_front(), c);
		cmp("weight_0", exp_w0.pop_front(), a[0]);
		cmp("weight_1", exp_w1.pop_front(), a[1]);
		cmp("weight_2", exp_w2.pop_front(), a[2]);
		cmp("weight_3", exp_w3.pop_front(), a[3]);
	endfunction
endclass

module testbench;
	localparam int WATCHDOG = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] op = OP_TRAIN;
	logic [5:0] neuron = 0;
	logic signed [15:0] value_0 = 0, value_1 = 0, value_2 = 0, value_3 = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [5:0] winner;
	logic [3:0] adapted_count;
	logic signed [15:0] weight_0, weight_1, weight_2, weight_3;

	som_scoreboard board;
	bit calm = 0;          // long stretch with no idling on either side
	bit hold_off = 0;      // receiver holds off completely
	int quiet_cycles = 0;

	always #6 clk = ~clk;

	som_winner_search_and_update_top u_top (.*);

	// Receiver: stall at random, or for a long hold-off; check every word taken.
	always @(posedge clk) begin
		logic [15:0] got [4];
		if (arst_n && out_valid && !out_stall) begin
			got[0] = weight_0; got[1] = weight_1; got[2] = weight_2; got[3] = weight_3;
			board.check_word(winner, adapted_count, got);
		end
		out_stall <= hold_off || (!calm && $urandom_range(99) < 7);
	end

	// Watchdog: count cycles with no handshake on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offer one word, hold it until taken, then note it on the scoreboard.
	// Valid stays high after the handshake so words can follow back to back;
	// an idle cycle or drain() drops it.
	task automatic send_word(op_t opc, logic [5:0] idx, logic signed [15:0] v [4]);
		while (!calm && $urandom_range(99) < 7) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		op <= opc; neuron <= idx;
		value_0 <= v[0]; value_1 <= v[1]; value_2 <= v[2]; value_3 <= v[3];
		do @(posedge clk); while (in_stall);
		board.note_word(opc, idx, v);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(reg_t idx, logic [31:0] val);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= 5'(4 * idx); pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	// Small random vector; sometimes the full range for extremes.
	function automatic void rand_vec(output logic signed [15:0] v [4]);
		for (int d = 0; d < 4; d++)
			v[d] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(8191)) - 4096);
	endfunction

	// Load every neuron of the grid in use so no search sees an unwritten entry.
	task automatic load_grid(int n);
		logic signed [15:0] v [4];
		for (int i = 0; i < n; i++) begin
			rand_vec(v);
			send_word(OP_LOAD, 6'(i), v);
		end
	endtask

	task automatic set_grid(int r, int c, mode_t m, int rch, int g0, int g1, int g2);
		drain();
		write_reg(REG_ROWS, r); write_reg(REG_COLS, c);
		write_reg(REG_MODE, m); write_reg(REG_REACH, rch);
		write_reg(REG_RATE0, g0); write_reg(REG_RATE1, g1); write_reg(REG_RATE2, g2);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic random_words(int count);
		logic signed [15:0] v [4];
		op_t opc;
		for (int i = 0; i < count; i++) begin
			rand_vec(v);
			case ($urandom_range(9))
				0, 1, 2, 3, 4: opc = OP_TRAIN;
				5, 6:          opc = OP_CLASSIFY;
				7:             opc = OP_LOAD;
				default:       opc = OP_READ;
			endcase
			send_word(opc, 6'($urandom_range(63)), v);
		end
	endtask

	initial begin
		logic signed [15:0] v [4];
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes of every field, every op and mode.
		load_grid(64);
		v = '{16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000};
		send_word(OP_LOAD, 6'd63, v);
		send_word(OP_READ, 6'd63, v);
		send_word(OP_TRAIN, 6'd0, v);
		send_word(OP_CLASSIFY, 6'd0, v);
		v = '{-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff};
		send_word(OP_TRAIN, 6'd0, v);
		v = '{0, 0, 0, 0};
		send_word(OP_LOAD, 6'd5, v); send_word(OP_LOAD, 6'd6, v);
		send_word(OP_CLASSIFY, 6'd0, v);   // tie: lowest index wins
		send_word(OP_READ, 6'd0, v);
		// Clamped grid size, reach three, full and zero gains, every mode.
		set_grid(0, 15, MODE_FOUR, 3, 65535, 65535, 65535);
		random_words(4);
		set_grid(15, 0, MODE_EIGHT, 2, 0, 0, 0);
		random_words(4);
		for (int m = 0; m < 4; m++) begin
			set_grid(8, 8, mode_t'(m), 2, 32768, 20000, 9000);
			random_words(5);
		end

		// Random phases across many settings.
		for (int ph = 0; ph < 24; ph++) begin
			set_grid($urandom_range(1, 8), $urandom_range(1, 8), mode_t'($urandom_range(3)),
				$urandom_range(3), $urandom, $urandom, $urandom);
			calm = (ph == 5);
			if (ph == 9) begin
				fork
					begin
						hold_off = 1;
						repeat (400) @(posedge clk);
						hold_off = 0;
					end
					random_words(10);
				join
			end
			random_words(45);
			if (ph == 12) drain();   // sender pauses until all results are in
		end
		calm = 0;
		drain();
		if (board.failures == 0 && board.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
